// ===== rtl/core/rmq_pkg.sv =====
// Shared types, codes and width helpers for the rotation matrix to quaternion core.
// No dependencies.
package rmq_pkg;

    localparam int ELEM_W = 16;
    localparam int MAG_W  = 17;
    localparam int LANES  = 3;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic [MAG_W-1:0] mag_t;

    typedef enum logic [1:0] {
        CASE_TRACE = 2'd0,
        CASE_X     = 2'd1,
        CASE_Y     = 2'd2,
        CASE_Z     = 2'd3
    } case_t;

    typedef struct packed {
        case_t kase;
        logic  bad;
    } ctrl_t;

    typedef struct packed {
        ctrl_t                ctrl;
        logic [LANES-1:0]     neg;
        mag_t [LANES-1:0]     mag;
    } item_t;

    // signed width of ONE +/- three elements
    function automatic int rad_width(input int f);
        return ((f > 17) ? f : 17) + 2;
    endfunction

    // width of floor(sqrt(rad * ONE))
    function automatic int root_width(input int f);
        return (rad_width(f) - 1 + f + 1) / 2;
    endfunction

    // width of mag * ONE + r
    function automatic int num_width(input int f);
        return MAG_W + f + 1;
    endfunction

endpackage

// ===== rtl/core/rotation_matrix_to_quaternion_core.sv =====
// Rotation matrix to quaternion core. Throughput: one matrix per cycle unless stalled.
// Pipeline in order: front register, queue, square root (one stage per root bit),
//   operand setup, divider (one stage per quotient bit) and output register;
//   RTW = (rad_width + FRAC_BITS) / 2, NUMW = FRAC_BITS + 18. Default is Q1.14.
// The whole back end stalls together while a result waits on m_ready.
// Reset (aresetn, synchronous, active low) clears all valid bits; no data state.
module rotation_matrix_to_quaternion_core #(
    parameter int FRAC_BITS = 14
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  rmq_pkg::elem_t  s_elem_r0c0,
    input  rmq_pkg::elem_t  s_elem_r0c1,
    input  rmq_pkg::elem_t  s_elem_r0c2,
    input  rmq_pkg::elem_t  s_elem_r1c0,
    input  rmq_pkg::elem_t  s_elem_r1c1,
    input  rmq_pkg::elem_t  s_elem_r1c2,
    input  rmq_pkg::elem_t  s_elem_r2c0,
    input  rmq_pkg::elem_t  s_elem_r2c1,
    input  rmq_pkg::elem_t  s_elem_r2c2,
    output logic            m_valid,
    input  logic            m_ready,
    output rmq_pkg::elem_t  m_quat_x,
    output rmq_pkg::elem_t  m_quat_y,
    output rmq_pkg::elem_t  m_quat_z,
    output rmq_pkg::elem_t  m_quat_w,
    output logic [1:0]      m_case_taken,
    output logic            m_bad_input
);
    import rmq_pkg::*;

    localparam int RADW = rad_width(FRAC_BITS);
    localparam int RTW  = root_width(FRAC_BITS);
    localparam int NUMW = num_width(FRAC_BITS);
    localparam int VW   = ((FRAC_BITS + 2) > ELEM_W) ? (FRAC_BITS + 2) : ELEM_W;
    localparam int QW   = RADW - 1 + $bits(item_t);
    localparam logic [FRAC_BITS:0] ONE_F = {1'b1, {FRAC_BITS{1'b0}}};

    logic            fr_valid, fr_ready;
    logic [RADW-2:0] fr_rad;
    item_t           fr_item;

    logic            q_valid;
    logic [QW-1:0]   q_data;
    logic            back_en;

    logic            sq_valid;
    logic [RTW-1:0]  sq_root;
    item_t           sq_item;

    logic            dv_valid;
    logic [RTW:0]    dv_dv;
    logic [NUMW-1:0] dv_q [LANES];
    logic [LANES-1:0] dv_neg;
    ctrl_t           dv_ctrl;

    logic signed [VW-1:0] lane_val [LANES];
    logic signed [VW-1:0] diag_val;
    logic [RTW:0]         diag_raw;
    elem_t qx_next, qy_next, qz_next, qw_next;

    logic  m_valid_reg;
    elem_t qx_reg, qy_reg, qz_reg, qw_reg;
    ctrl_t ctrl_reg;

    assign back_en = !m_valid_reg || m_ready;

    rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_elem_r0c0 (s_elem_r0c0),
        .s_elem_r0c1 (s_elem_r0c1),
        .s_elem_r0c2 (s_elem_r0c2),
        .s_elem_r1c0 (s_elem_r1c0),
        .s_elem_r1c1 (s_elem_r1c1),
        .s_elem_r1c2 (s_elem_r1c2),
        .s_elem_r2c0 (s_elem_r2c0),
        .s_elem_r2c1 (s_elem_r2c1),
        .s_elem_r2c2 (s_elem_r2c2),
        .out_valid   (fr_valid),
        .out_ready   (fr_ready),
        .out_rad     (fr_rad),
        .out_item    (fr_item)
    );

    rmq_fifo #(.W(QW)) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   ({fr_rad, fr_item}),
        .out_valid (q_valid),
        .out_pop   (back_en),
        .out_data  (q_data)
    );

    rmq_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (back_en),
        .in_valid  (q_valid),
        .in_rad    (q_data[QW-1 -: (RADW-1)]),
        .in_item   (item_t'(q_data[$bits(item_t)-1:0])),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_item  (sq_item)
    );

    rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (back_en),
        .in_valid  (sq_valid),
        .in_root   (sq_root),
        .in_item   (sq_item),
        .out_valid (dv_valid),
        .out_dv    (dv_dv),
        .out_q     (dv_q),
        .out_neg   (dv_neg),
        .out_ctrl  (dv_ctrl)
    );

    // saturate to ONE, apply sign; diagonal component is r/2 = (2r)/4
    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            lane_val[j] = (dv_q[j] > NUMW'(ONE_F)) ? VW'(ONE_F)
                                                   : VW'(dv_q[j][FRAC_BITS:0]);
            if (dv_neg[j]) begin
                lane_val[j] = -lane_val[j];
            end
        end
        diag_raw = dv_dv >> 2;
        diag_val = (diag_raw > (RTW + 1)'(ONE_F)) ? VW'(ONE_F)
                                                  : VW'(diag_raw[FRAC_BITS:0]);
    end

    always_comb begin
        unique case (dv_ctrl.kase)
            CASE_TRACE: begin
                qx_next = lane_val[0][ELEM_W-1:0];
                qy_next = lane_val[1][ELEM_W-1:0];
                qz_next = lane_val[2][ELEM_W-1:0];
                qw_next = diag_val[ELEM_W-1:0];
            end
            CASE_X: begin
                qx_next = diag_val[ELEM_W-1:0];
                qy_next = lane_val[0][ELEM_W-1:0];
                qz_next = lane_val[1][ELEM_W-1:0];
                qw_next = lane_val[2][ELEM_W-1:0];
            end
            CASE_Y: begin
                qx_next = lane_val[0][ELEM_W-1:0];
                qy_next = diag_val[ELEM_W-1:0];
                qz_next = lane_val[1][ELEM_W-1:0];
                qw_next = lane_val[2][ELEM_W-1:0];
            end
            default: begin
                qx_next = lane_val[0][ELEM_W-1:0];
                qy_next = lane_val[1][ELEM_W-1:0];
                qz_next = diag_val[ELEM_W-1:0];
                qw_next = lane_val[2][ELEM_W-1:0];
            end
        endcase
        if (dv_ctrl.bad) begin
            qx_next = '0;
            qy_next = '0;
            qz_next = '0;
            qw_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (back_en) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (back_en) begin
            qx_reg   <= qx_next;
            qy_reg   <= qy_next;
            qz_reg   <= qz_next;
            qw_reg   <= qw_next;
            ctrl_reg <= dv_ctrl;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_quat_x     = qx_reg;
    assign m_quat_y     = qy_reg;
    assign m_quat_z     = qz_reg;
    assign m_quat_w     = qw_reg;
    assign m_case_taken = ctrl_reg.kase;
    assign m_bad_input  = ctrl_reg.bad;

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bad_input) |->
            (m_quat_x == '0 && m_quat_y == '0 && m_quat_z == '0 && m_quat_w == '0))
        else $error("bad input result carries nonzero components");

    a_stall_freezes_back: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !back_en)
        else $error("back end advanced while result is stalled");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

// ===== rtl/core/rmq_front.sv =====
// Front end: accepts a matrix, picks the case, forms radicand and off-diagonal terms.
// Depends on rmq_pkg.
module rmq_front #(
    parameter int FRAC_BITS = 14
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  rmq_pkg::elem_t  s_elem_r0c0,
    input  rmq_pkg::elem_t  s_elem_r0c1,
    input  rmq_pkg::elem_t  s_elem_r0c2,
    input  rmq_pkg::elem_t  s_elem_r1c0,
    input  rmq_pkg::elem_t  s_elem_r1c1,
    input  rmq_pkg::elem_t  s_elem_r1c2,
    input  rmq_pkg::elem_t  s_elem_r2c0,
    input  rmq_pkg::elem_t  s_elem_r2c1,
    input  rmq_pkg::elem_t  s_elem_r2c2,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [rmq_pkg::rad_width(FRAC_BITS)-2:0] out_rad,
    output rmq_pkg::item_t  out_item
);
    import rmq_pkg::*;

    localparam int RADW = rad_width(FRAC_BITS);
    localparam logic signed [RADW-1:0] ONE_R = {{(RADW-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic signed [RADW-1:0] e00, e11, e22;
    logic signed [RADW-1:0] rad_t, rad_x, rad_y, rad_z, rad_sel;
    logic signed [MAG_W-1:0] d [LANES];
    case_t kase;
    logic  bad;
    item_t item_next;

    logic valid_reg;
    logic [RADW-2:0] rad_reg;
    item_t item_reg;

    assign e00 = RADW'(s_elem_r0c0);
    assign e11 = RADW'(s_elem_r1c1);
    assign e22 = RADW'(s_elem_r2c2);

    assign rad_t = ONE_R + e00 + e11 + e22;
    assign rad_x = ONE_R + e00 - e11 - e22;
    assign rad_y = ONE_R + e11 - e00 - e22;
    assign rad_z = ONE_R + e22 - e00 - e11;

    always_comb begin
        priority if (rad_t > 0) begin
            kase    = CASE_TRACE;
            rad_sel = rad_t;
        end else if (s_elem_r0c0 > s_elem_r1c1 && s_elem_r0c0 > s_elem_r2c2) begin
            kase    = CASE_X;
            rad_sel = rad_x;
        end else if (s_elem_r1c1 > s_elem_r2c2) begin
            kase    = CASE_Y;
            rad_sel = rad_y;
        end else begin
            kase    = CASE_Z;
            rad_sel = rad_z;
        end
    end

    assign bad = (rad_sel <= 0);

    // off-diagonal terms in output order, skipping the diagonal component
    always_comb begin
        unique case (kase)
            CASE_TRACE: begin
                d[0] = MAG_W'(s_elem_r2c1) - MAG_W'(s_elem_r1c2);
                d[1] = MAG_W'(s_elem_r0c2) - MAG_W'(s_elem_r2c0);
                d[2] = MAG_W'(s_elem_r1c0) - MAG_W'(s_elem_r0c1);
            end
            CASE_X: begin
                d[0] = MAG_W'(s_elem_r0c1) + MAG_W'(s_elem_r1c0);
                d[1] = MAG_W'(s_elem_r0c2) + MAG_W'(s_elem_r2c0);
                d[2] = MAG_W'(s_elem_r2c1) - MAG_W'(s_elem_r1c2);
            end
            CASE_Y: begin
                d[0] = MAG_W'(s_elem_r0c1) + MAG_W'(s_elem_r1c0);
                d[1] = MAG_W'(s_elem_r1c2) + MAG_W'(s_elem_r2c1);
                d[2] = MAG_W'(s_elem_r0c2) - MAG_W'(s_elem_r2c0);
            end
            default: begin
                d[0] = MAG_W'(s_elem_r0c2) + MAG_W'(s_elem_r2c0);
                d[1] = MAG_W'(s_elem_r1c2) + MAG_W'(s_elem_r2c1);
                d[2] = MAG_W'(s_elem_r1c0) - MAG_W'(s_elem_r0c1);
            end
        endcase
    end

    always_comb begin
        item_next.ctrl.kase = kase;
        item_next.ctrl.bad  = bad;
        for (int j = 0; j < LANES; j++) begin
            item_next.neg[j] = d[j][MAG_W-1];
            item_next.mag[j] = d[j][MAG_W-1] ? mag_t'(-d[j]) : mag_t'(d[j]);
        end
    end

    assign s_ready   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            rad_reg  <= bad ? '0 : rad_sel[RADW-2:0];
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/core/rmq_fifo.sv =====
// Two-entry request queue between the front end and the arithmetic back end.
// No dependencies.
module rmq_fifo #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_pop,
    output logic [W-1:0] out_data
);
    logic [W-1:0] mem_reg [2];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== rtl/core/rmq_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, payload carried alongside.
// Depends on rmq_pkg.
module rmq_sqrt #(
    parameter int FRAC_BITS = 14
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [rmq_pkg::rad_width(FRAC_BITS)-2:0] in_rad,
    input  rmq_pkg::item_t  in_item,
    output logic            out_valid,
    output logic [rmq_pkg::root_width(FRAC_BITS)-1:0] out_root,
    output rmq_pkg::item_t  out_item
);
    import rmq_pkg::*;

    localparam int RTW  = root_width(FRAC_BITS);
    localparam int NP   = 2 * RTW;
    localparam int REMW = RTW + 3;

    logic [REMW-1:0] rem_in   [RTW];
    logic [RTW-1:0]  root_in  [RTW];
    logic [NP-1:0]   nb_in    [RTW];
    logic [RTW-1:0]  v_in;
    item_t           item_in  [RTW];

    logic [REMW-1:0] rem_reg  [RTW];
    logic [RTW-1:0]  root_reg [RTW];
    logic [NP-1:0]   nb_reg   [RTW];
    logic [RTW-1:0]  v_reg;
    item_t           item_reg [RTW];

    for (genvar k = 0; k < RTW; k++) begin : g_stage
        logic [REMW-1:0] cur, trial;
        logic ge;

        if (k == 0) begin : g_first
            assign rem_in[k]  = '0;
            assign root_in[k] = '0;
            assign nb_in[k]   = NP'(in_rad) << FRAC_BITS;
            assign v_in[k]    = in_valid;
            assign item_in[k] = in_item;
        end else begin : g_next
            assign rem_in[k]  = rem_reg[k-1];
            assign root_in[k] = root_reg[k-1];
            assign nb_in[k]   = nb_reg[k-1];
            assign v_in[k]    = v_reg[k-1];
            assign item_in[k] = item_reg[k-1];
        end

        assign cur   = {rem_in[k][REMW-3:0], nb_in[k][NP-1 -: 2]};
        assign trial = {1'b0, root_in[k], 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? (cur - trial) : cur;
                root_reg[k] <= {root_in[k][RTW-2:0], ge};
                nb_reg[k]   <= nb_in[k] << 2;
                item_reg[k] <= item_in[k];
            end
        end
    end

    assign out_valid = v_reg[RTW-1];
    assign out_root  = root_reg[RTW-1];
    assign out_item  = item_reg[RTW-1];

endmodule

// ===== rtl/core/rmq_div.sv =====
// Pipelined restoring divider, three lanes sharing divisor 2r, one quotient bit per stage.
// Depends on rmq_pkg.
module rmq_div #(
    parameter int FRAC_BITS = 14
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [rmq_pkg::root_width(FRAC_BITS)-1:0] in_root,
    input  rmq_pkg::item_t  in_item,
    output logic            out_valid,
    output logic [rmq_pkg::root_width(FRAC_BITS):0] out_dv,
    output logic [rmq_pkg::num_width(FRAC_BITS)-1:0] out_q [rmq_pkg::LANES],
    output logic [rmq_pkg::LANES-1:0] out_neg,
    output rmq_pkg::ctrl_t  out_ctrl
);
    import rmq_pkg::*;

    localparam int RTW  = root_width(FRAC_BITS);
    localparam int NUMW = num_width(FRAC_BITS);
    localparam int DRW  = RTW + 2;

    // operand setup: numerator = mag * ONE + r (rounds to nearest), divisor = 2r
    logic            p_v_reg;
    logic [NUMW-1:0] p_num_reg [LANES];
    logic [RTW:0]    p_dv_reg;
    logic [LANES-1:0] p_neg_reg;
    ctrl_t           p_ctrl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_v_reg <= 1'b0;
        end else if (en) begin
            p_v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < LANES; j++) begin
                p_num_reg[j] <= (NUMW'(in_item.mag[j]) << FRAC_BITS) + NUMW'(in_root);
            end
            p_dv_reg   <= {in_root, 1'b0};
            p_neg_reg  <= in_item.neg;
            p_ctrl_reg <= in_item.ctrl;
        end
    end

    logic [DRW-1:0]  rem_in  [NUMW][LANES];
    logic [NUMW-1:0] q_in    [NUMW][LANES];
    logic [NUMW-1:0] nb_in   [NUMW][LANES];
    logic [RTW:0]    dv_in   [NUMW];
    logic [LANES-1:0] neg_in [NUMW];
    ctrl_t           ctrl_in [NUMW];
    logic [NUMW-1:0] v_in;

    logic [DRW-1:0]  rem_reg  [NUMW][LANES];
    logic [NUMW-1:0] q_reg    [NUMW][LANES];
    logic [NUMW-1:0] nb_reg   [NUMW][LANES];
    logic [RTW:0]    dv_reg   [NUMW];
    logic [LANES-1:0] neg_reg [NUMW];
    ctrl_t           ctrl_reg [NUMW];
    logic [NUMW-1:0] v_reg;

    for (genvar k = 0; k < NUMW; k++) begin : g_stage
        if (k == 0) begin : g_first
            for (genvar j = 0; j < LANES; j++) begin : g_lane_in
                assign rem_in[k][j] = '0;
                assign q_in[k][j]   = '0;
                assign nb_in[k][j]  = p_num_reg[j];
            end
            assign dv_in[k]   = p_dv_reg;
            assign neg_in[k]  = p_neg_reg;
            assign ctrl_in[k] = p_ctrl_reg;
            assign v_in[k]    = p_v_reg;
        end else begin : g_next
            for (genvar j = 0; j < LANES; j++) begin : g_lane_in
                assign rem_in[k][j] = rem_reg[k-1][j];
                assign q_in[k][j]   = q_reg[k-1][j];
                assign nb_in[k][j]  = nb_reg[k-1][j];
            end
            assign dv_in[k]   = dv_reg[k-1];
            assign neg_in[k]  = neg_reg[k-1];
            assign ctrl_in[k] = ctrl_reg[k-1];
            assign v_in[k]    = v_reg[k-1];
        end

        for (genvar j = 0; j < LANES; j++) begin : g_lane
            logic [DRW-1:0] cur, dvx;
            logic ge;

            assign cur = {rem_in[k][j][DRW-2:0], nb_in[k][j][NUMW-1]};
            assign dvx = {1'b0, dv_in[k]};
            assign ge  = (cur >= dvx);

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k][j] <= ge ? (cur - dvx) : cur;
                    q_reg[k][j]   <= {q_in[k][j][NUMW-2:0], ge};
                    nb_reg[k][j]  <= nb_in[k][j] << 1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_reg[k]   <= dv_in[k];
                neg_reg[k]  <= neg_in[k];
                ctrl_reg[k] <= ctrl_in[k];
            end
        end
    end

    assign out_valid = v_reg[NUMW-1];
    assign out_dv    = dv_reg[NUMW-1];
    assign out_neg   = neg_reg[NUMW-1];
    assign out_ctrl  = ctrl_reg[NUMW-1];
    for (genvar j = 0; j < LANES; j++) begin : g_out
        assign out_q[j] = q_reg[NUMW-1][j];
    end

endmodule
